FILE: src/eea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eea_pkg;

    localparam int CNT_W        = 32;
    localparam int PPR_W        = 15;
    localparam int PP_W         = 7;
    localparam int ANGLE_W      = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 15;

    localparam int FOLD_LIMIT_REVS  = 50;
    localparam int FOLD_STEP_REVS   = 30;
    localparam int COUNTS_PER_LINE  = 4;
    localparam int ANGLE_FRAC_BITS  = 14;

    localparam int LINE_SHIFT   = 2;
    localparam int PER_REV_W    = PPR_W + LINE_SHIFT;
    localparam int SCALED_W     = PER_REV_W + ANGLE_FRAC_BITS;
    localparam int LIMIT_MULT   = FOLD_LIMIT_REVS * COUNTS_PER_LINE;
    localparam int STEP_MULT    = FOLD_STEP_REVS * COUNTS_PER_LINE;
    localparam int LIMIT_W      = 23;
    localparam int STEP_W       = 22;
    localparam int PROD_W       = ANGLE_W + PP_W;

    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_CNT_W      = 4;
    localparam logic [DIV_CNT_W-1:0] DIV1_LAST = DIV_CNT_W'(CNT_W / DIV_RADIX_BITS - 1);
    localparam logic [DIV_CNT_W-1:0] DIV2_LAST = DIV_CNT_W'(ANGLE_W / DIV_RADIX_BITS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PPR        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POLE_PAIRS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ABZ_MODE   = 2'd2;

    localparam logic [PPR_W-1:0] PPR_RESET      = 15'd1024;
    localparam logic [PP_W-1:0]  PP_RESET       = 7'd4;
    localparam logic             ABZ_MODE_RESET = 1'b1;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_second;
        logic path_abz;
        logic mech_load;
        logic angle_store;
        logic fold;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic rezero;
        logic div_done;
        logic abz_mode;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: src/eea_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface eea_in_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic signed [eea_pkg::CNT_W-1:0]   counter_value;

    modport source (output valid, command, counter_value, input ready);
    modport sink   (input valid, command, counter_value, output ready);
endinterface

interface eea_out_if;
    logic                           valid;
    logic                           ready;
    logic [eea_pkg::ANGLE_W-1:0]    electrical_angle;
    logic [eea_pkg::ANGLE_W-1:0]    abz_electrical_angle;

    modport source (output valid, electrical_angle, abz_electrical_angle, input ready);
    modport sink   (input valid, electrical_angle, abz_electrical_angle, output ready);
endinterface

`default_nettype wire

FILE: src/eea_div.sv
`timescale 1ns / 1ps
`default_nettype none

module eea_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [eea_pkg::PER_REV_W-1:0]       i_init_rem,
    input  logic [eea_pkg::CNT_W-1:0]           i_bits,
    input  logic [eea_pkg::PER_REV_W-1:0]       i_divisor,
    input  logic [eea_pkg::DIV_CNT_W-1:0]       i_last,
    output logic                                o_done,
    output logic [eea_pkg::PER_REV_W-1:0]       o_rem,
    output logic [eea_pkg::ANGLE_W-1:0]         o_quot
);

    logic                               r_busy;
    logic                               r_done;
    logic [eea_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [eea_pkg::PER_REV_W-1:0]      r_rem;
    logic [eea_pkg::PER_REV_W-1:0]      r_div;
    logic [eea_pkg::CNT_W-1:0]          r_bits;

    logic [eea_pkg::PER_REV_W:0]        step1;
    logic [eea_pkg::PER_REV_W:0]        step2;
    logic [eea_pkg::PER_REV_W:0]        left1;
    logic                               ge1;
    logic                               ge2;
    logic [eea_pkg::PER_REV_W-1:0]      n_rem;
    logic [eea_pkg::CNT_W-1:0]          n_bits;

    // two restoring steps per cycle
    always_comb begin
        step1 = {r_rem, r_bits[eea_pkg::CNT_W-1]};
        ge1   = step1 >= {1'b0, r_div};
        left1 = ge1 ? (step1 - {1'b0, r_div}) : step1;
        step2 = {left1[eea_pkg::PER_REV_W-1:0], r_bits[eea_pkg::CNT_W-2]};
        ge2   = step2 >= {1'b0, r_div};
        n_rem = ge2 ? eea_pkg::PER_REV_W'(step2 - {1'b0, r_div})
                    : step2[eea_pkg::PER_REV_W-1:0];
        n_bits = {r_bits[eea_pkg::CNT_W-3:0], ge1, ge2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= i_last;
            r_rem  <= i_init_rem;
            r_div  <= i_divisor;
            r_bits <= i_bits;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_rem  <= n_rem;
            r_bits <= n_bits;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_quot = r_bits[eea_pkg::ANGLE_W-1:0];

endmodule

`default_nettype wire

FILE: src/eea_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module eea_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  eea_pkg::t_dp_cmd                    i_cmd,
    output eea_pkg::t_dp_status                 o_status,
    input  logic                                i_cfg_we,
    input  logic [eea_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [eea_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_command,
    input  logic signed [eea_pkg::CNT_W-1:0]    i_counter_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [eea_pkg::ANGLE_W-1:0]         o_electrical_angle,
    output logic [eea_pkg::ANGLE_W-1:0]         o_abz_electrical_angle
);

    logic [eea_pkg::PPR_W-1:0]      r_ppr;
    logic [eea_pkg::PP_W-1:0]       r_pp;
    logic                           r_abz_mode;
    logic [eea_pkg::LIMIT_W-1:0]    r_limit;
    logic [eea_pkg::STEP_W-1:0]     r_step;

    logic [eea_pkg::CNT_W-1:0]      r_base;
    logic [eea_pkg::CNT_W-1:0]      r_rt;
    logic [eea_pkg::CNT_W-1:0]      r_abz_base;
    logic [eea_pkg::CNT_W-1:0]      r_abz_rt;
    logic [eea_pkg::ANGLE_W-1:0]    r_held;

    logic                           r_cmd;
    logic                           r_neg;
    logic [eea_pkg::ANGLE_W-1:0]    r_mech;
    logic [eea_pkg::ANGLE_W-1:0]    r_elec;

    logic                           r_out_valid;
    logic [eea_pkg::ANGLE_W-1:0]    r_out_elec;
    logic [eea_pkg::ANGLE_W-1:0]    r_out_abz;

    logic [eea_pkg::CNT_W-1:0]      cnt_u;
    logic [eea_pkg::CNT_W-1:0]      n_rt;
    logic [eea_pkg::CNT_W-1:0]      n_abz_rt;
    logic [eea_pkg::CNT_W-1:0]      sel_total;
    logic [eea_pkg::CNT_W-1:0]      sel_mag;
    logic [eea_pkg::SCALED_W-1:0]   scaled;
    logic [eea_pkg::ANGLE_W-1:0]    mech_val;
    logic [eea_pkg::PROD_W-1:0]     prod;

    logic [eea_pkg::PER_REV_W-1:0]  div_init;
    logic [eea_pkg::CNT_W-1:0]      div_bits;
    logic [eea_pkg::PER_REV_W-1:0]  div_divisor;
    logic [eea_pkg::DIV_CNT_W-1:0]  div_last;
    logic                           div_done;
    logic [eea_pkg::PER_REV_W-1:0]  div_rem;
    logic [eea_pkg::ANGLE_W-1:0]    div_quot;

    // totals beyond fifty turns are pulled back by thirty
    function automatic logic [eea_pkg::CNT_W-1:0] fold_total(
        input logic [eea_pkg::CNT_W-1:0]    total,
        input logic [eea_pkg::LIMIT_W-1:0]  limit,
        input logic [eea_pkg::STEP_W-1:0]   step
    );
        logic [eea_pkg::CNT_W-1:0] mag;
        logic [eea_pkg::CNT_W-1:0] res;
        mag = total[eea_pkg::CNT_W-1] ? (~total + 1'b1) : total;
        res = total;
        if (mag > eea_pkg::CNT_W'(limit)) begin
            res = total[eea_pkg::CNT_W-1] ? (total + eea_pkg::CNT_W'(step))
                                          : (total - eea_pkg::CNT_W'(step));
        end
        return res;
    endfunction

    always_comb begin
        cnt_u     = $unsigned(i_counter_value);
        n_rt      = r_rt + cnt_u - r_base;
        n_abz_rt  = r_abz_rt + cnt_u - r_abz_base;
        sel_total = i_cmd.path_abz ? r_abz_rt : r_rt;
        sel_mag   = sel_total[eea_pkg::CNT_W-1] ? (~sel_total + 1'b1) : sel_total;
        scaled    = {div_rem, {eea_pkg::ANGLE_FRAC_BITS{1'b0}}};
        if (i_cmd.div_second) begin
            div_init    = eea_pkg::PER_REV_W'(scaled[eea_pkg::SCALED_W-1:eea_pkg::ANGLE_W]);
            div_bits    = {scaled[eea_pkg::ANGLE_W-1:0],
                           {(eea_pkg::CNT_W-eea_pkg::ANGLE_W){1'b0}}};
            div_divisor = eea_pkg::PER_REV_W'(r_ppr);
            div_last    = eea_pkg::DIV2_LAST;
        end else begin
            div_init    = '0;
            div_bits    = sel_mag;
            div_divisor = {r_ppr, {eea_pkg::LINE_SHIFT{1'b0}}};
            div_last    = eea_pkg::DIV1_LAST;
        end
        if (r_ppr == '0) begin
            mech_val = '0;
        end else begin
            mech_val = r_neg ? (~div_quot + 1'b1) : div_quot;
        end
        prod = eea_pkg::PROD_W'(r_mech) * eea_pkg::PROD_W'(r_pp);
    end

    eea_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_init_rem (div_init),
        .i_bits     (div_bits),
        .i_divisor  (div_divisor),
        .i_last     (div_last),
        .o_done     (div_done),
        .o_rem      (div_rem),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr       <= eea_pkg::PPR_RESET;
            r_pp        <= eea_pkg::PP_RESET;
            r_abz_mode  <= eea_pkg::ABZ_MODE_RESET;
            r_base      <= '0;
            r_rt        <= '0;
            r_abz_base  <= '0;
            r_abz_rt    <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == eea_pkg::CFG_IDX_PPR)) begin
                r_ppr <= i_cfg_data[eea_pkg::PPR_W-1:0];
            end
            if (i_cfg_we && (i_cfg_index == eea_pkg::CFG_IDX_POLE_PAIRS)) begin
                r_pp <= i_cfg_data[eea_pkg::PP_W-1:0];
            end
            if (i_cfg_we && (i_cfg_index == eea_pkg::CFG_IDX_ABZ_MODE)) begin
                r_abz_mode <= i_cfg_data[0];
            end

            if (i_cmd.accept) begin
                r_base <= cnt_u;
                if (i_command) begin
                    r_rt <= '0;
                end else begin
                    r_rt <= n_rt;
                    if (r_abz_mode) begin
                        r_abz_rt   <= n_abz_rt;
                        r_abz_base <= cnt_u;
                    end
                end
            end else if (i_cmd.fold) begin
                r_rt     <= fold_total(r_rt, r_limit, r_step);
                r_abz_rt <= fold_total(r_abz_rt, r_limit, r_step);
            end

            if (i_cmd.angle_store && i_cmd.path_abz) begin
                r_held <= prod[eea_pkg::ANGLE_W-1:0];
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= eea_pkg::LIMIT_W'(r_ppr) * eea_pkg::LIMIT_W'(eea_pkg::LIMIT_MULT);
        r_step  <= eea_pkg::STEP_W'(r_ppr) * eea_pkg::STEP_W'(eea_pkg::STEP_MULT);
        if (i_cmd.accept) begin
            r_cmd  <= i_command;
            r_elec <= '0;
        end
        if (i_cmd.div_start && !i_cmd.div_second) begin
            r_neg <= sel_total[eea_pkg::CNT_W-1];
        end
        if (i_cmd.mech_load) begin
            r_mech <= mech_val;
        end
        if (i_cmd.angle_store && !i_cmd.path_abz) begin
            r_elec <= prod[eea_pkg::ANGLE_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_elec <= r_elec;
            r_out_abz  <= r_held;
        end
    end

    always_comb begin
        o_status.rezero   = r_cmd;
        o_status.div_done = div_done;
        o_status.abz_mode = r_abz_mode;
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid            = r_out_valid;
    assign o_electrical_angle     = r_out_elec;
    assign o_abz_electrical_angle = r_out_abz;

endmodule

`default_nettype wire

FILE: src/eea_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module eea_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    output eea_pkg::t_dp_cmd        o_cmd,
    input  eea_pkg::t_dp_status     i_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV1,
        S_DIV1_WAIT,
        S_DIV2,
        S_DIV2_WAIT,
        S_MECH,
        S_ELEC,
        S_FOLD,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_path_abz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_path_abz <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_DIV1;
                        r_path_abz <= 1'b0;
                    end
                end
                S_DIV1: begin
                    r_state <= i_status.rezero ? S_DONE : S_DIV1_WAIT;
                end
                S_DIV1_WAIT: begin
                    if (i_status.div_done) begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    r_state <= S_DIV2_WAIT;
                end
                S_DIV2_WAIT: begin
                    if (i_status.div_done) begin
                        r_state <= S_MECH;
                    end
                end
                S_MECH: begin
                    r_state <= S_ELEC;
                end
                S_ELEC: begin
                    if (!r_path_abz && i_status.abz_mode) begin
                        r_state    <= S_DIV1;
                        r_path_abz <= 1'b1;
                    end else begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_in_ready        = (r_state == S_IDLE);
        o_cmd.accept      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_start   = ((r_state == S_DIV1) && !i_status.rezero) || (r_state == S_DIV2);
        o_cmd.div_second  = (r_state == S_DIV2);
        o_cmd.path_abz    = r_path_abz;
        o_cmd.mech_load   = (r_state == S_MECH);
        o_cmd.angle_store = (r_state == S_ELEC);
        o_cmd.fold        = (r_state == S_FOLD);
        o_cmd.out_load    = (r_state == S_DONE) && i_status.out_free;
    end

endmodule

`default_nettype wire

FILE: src/encoder_electrical_angle.sv
// encoder_electrical_angle
// Turns samples of a free-running 32-bit quadrature counter into a 16-bit
// electrical angle, plus a second angle from an independent ABZ accumulator.
// Channels: i_sample carries command (0 sample, 1 rezero) and counter_value;
// o_angle carries electrical_angle and abz_electrical_angle. A transaction
// happens when valid and ready are both high at a rising edge.
// Configuration: i_cfg_we, i_cfg_index (0 pulses per rev, 1 pole pairs,
// 2 abz mode) and i_cfg_data; write only while no transaction is in flight.
// Timing: one item at a time. The two divisions per angle run in one shared
// radix-4 divider (16 steps for the remainder, 8 for the scaled quotient);
// with ABZ mode on both angles go through it in turn, and a rezero skips
// the divider. The next sample is taken in the cycle after the result is
// loaded into the output register.
// Reset: synchronous, active low; totals, baselines and the held ABZ angle
// clear, configuration returns to 1024 lines, 4 pole pairs, ABZ mode on.
// Stall: a result waits in the output register; the block finishes the next
// item and then holds it until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module encoder_electrical_angle (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    eea_in_if.sink                              i_sample,
    eea_out_if.source                           o_angle,
    input  logic                                i_cfg_we,
    input  logic [eea_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [eea_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    eea_pkg::t_dp_cmd       dp_cmd;
    eea_pkg::t_dp_status    dp_status;
    logic                   in_ready;
    logic                   out_valid;
    logic [eea_pkg::ANGLE_W-1:0] elec;
    logic [eea_pkg::ANGLE_W-1:0] abz_elec;

    eea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd),
        .i_status   (dp_status)
    );

    eea_dp u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (dp_cmd),
        .o_status               (dp_status),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_command              (i_sample.command),
        .i_counter_value        (i_sample.counter_value),
        .o_out_valid            (out_valid),
        .i_out_ready            (o_angle.ready),
        .o_electrical_angle     (elec),
        .o_abz_electrical_angle (abz_elec)
    );

    assign i_sample.ready               = in_ready;
    assign o_angle.valid                = out_valid;
    assign o_angle.electrical_angle     = elec;
    assign o_angle.abz_electrical_angle = abz_elec;

endmodule

`default_nettype wire

FILE: src/eea_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module eea_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_in_command,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [eea_pkg::ANGLE_W-1:0] i_out_elec
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // no result pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input taken again while busy");

    // a new result only comes out of a busy cycle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result without work");

    // rezero into an empty output gives a valid result of angle zero
    a_rezero_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_command && !i_out_valid) |-> ##3 (i_out_valid && (i_out_elec == '0)))
        else $error("rezero result wrong");

    // stalled transaction holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_elec)))
        else $error("stalled result changed");

endmodule

bind encoder_electrical_angle eea_checker u_eea_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_sample.valid),
    .i_in_ready     (i_sample.ready),
    .i_in_command   (i_sample.command),
    .i_out_valid    (o_angle.valid),
    .i_out_ready    (o_angle.ready),
    .i_out_elec     (o_angle.electrical_angle)
);

`default_nettype wire
